/* hdl/u16u8_pkg.sv */
`timescale 1ns / 1ps
// Package for the UTF-16 to UTF-8 transcoder: job record, byte-run record,
// surrogate tags and the UTF-8 encode function. No dependencies.
package u16u8_pkg;

   // Upper six bits of a surrogate code unit
   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

   // Code point range limits
   localparam logic [20:0] LIMIT_1BYTE = 21'h00080;
   localparam logic [20:0] LIMIT_2BYTE = 21'h00800;
   localparam logic [20:0] LIMIT_3BYTE = 21'h10000;

   // UTF-8 lead and continuation prefixes
   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [4:0] LEAD4_TAG = 5'b11110;
   localparam logic [1:0] CONT_TAG  = 2'b10;

   localparam int QUEUE_DEPTH = 2;

   // Encoded code point: up to four bytes, b[0] goes first
   typedef struct packed {
      logic [3:0][7:0] b;
      logic [2:0]      n;
   } enc_type;

   // One item's worth of output bytes, handed from front to back
   typedef struct packed {
      logic [5:0][7:0] bytes;
      logic [2:0]      count;
      logic            str_end;
   } job_type;

   function automatic enc_type utf8_encode(input logic [20:0] cp);
      enc_type e;
      e = '0;
      if (cp < LIMIT_1BYTE) begin
         e.b[0] = cp[7:0];
         e.n    = 3'd1;
      end else if (cp < LIMIT_2BYTE) begin
         e.b[0] = {LEAD2_TAG, cp[10:6]};
         e.b[1] = {CONT_TAG, cp[5:0]};
         e.n    = 3'd2;
      end else if (cp < LIMIT_3BYTE) begin
         e.b[0] = {LEAD3_TAG, cp[15:12]};
         e.b[1] = {CONT_TAG, cp[11:6]};
         e.b[2] = {CONT_TAG, cp[5:0]};
         e.n    = 3'd3;
      end else begin
         e.b[0] = {LEAD4_TAG, cp[20:18]};
         e.b[1] = {CONT_TAG, cp[17:12]};
         e.b[2] = {CONT_TAG, cp[11:6]};
         e.b[3] = {CONT_TAG, cp[5:0]};
         e.n    = 3'd4;
      end
      return e;
   endfunction

endpackage

/* hdl/utf16_to_utf8_transcoder.sv */
`timescale 1ns / 1ps
// UTF-16 to UTF-8 transcoder, top level. Depends on u16u8_pkg, u16u8_front,
// u16u8_queue and u16u8_back.
//
// Takes one UTF-16 code unit per item and delivers UTF-8 one byte per
// output item. A high surrogate is parked until the next unit: a following
// low surrogate makes a 4-byte sequence, anything else sends the parked
// surrogate out alone as 3 bytes before the new unit. Lone surrogates are
// encoded as 3 bytes, and a high surrogate flagged as string end is not
// parked. An item that only parks a surrogate produces no bytes. Each item
// yields 0 to 6 bytes; the back end emits one byte per cycle unless
// rsp_stall holds it, so the item rate follows each item's byte count (1 to
// 3 for BMP text). The front end accepts a new item every cycle while the
// 2-entry job queue has room, so input and output stall independently.
// rsp_run_last marks the last byte of an item, rsp_string_last the final
// byte of a string. A queued job's bytes pass through the output register.
module utf16_to_utf8_transcoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code_unit,
   input  logic        req_string_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_last
);
   import u16u8_pkg::*;

   logic    accept;
   logic    push, pop, full, nonempty;
   job_type new_job, head_job;

   // stall comes straight from the queue fill flag, not from rsp_stall
   assign req_stall = full;
   assign accept    = req_valid && !full;

   // classify and build the job
   u16u8_front front_i (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .code_unit  (req_code_unit),
      .string_end (req_string_end),
      .push       (push),
      .job        (new_job)
   );

   // decouples input and output stalls
   u16u8_queue queue_i (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (new_job),
      .pop       (pop),
      .full      (full),
      .nonempty  (nonempty),
      .head      (head_job)
   );

   // serialize bytes into the output register
   u16u8_back back_i (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (nonempty),
      .job             (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_last (rsp_string_last)
   );

endmodule

/* hdl/u16u8_front.sv */
`timescale 1ns / 1ps
// Front end: classifies code units, holds a pending high surrogate and
// builds the byte job for each item. Depends on u16u8_pkg.
module u16u8_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [15:0]        code_unit,
   input  logic               string_end,
   output logic               push,
   output u16u8_pkg::job_type job
);
   import u16u8_pkg::*;

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_bits_ff, held_bits_in;
   logic       is_high, is_low, hold_now;
   enc_type    enc_pair, enc_held, enc_cur;

   assign is_high  = (code_unit[15:10] == HIGH_SURR_TAG);
   assign is_low   = (code_unit[15:10] == LOW_SURR_TAG);
   assign hold_now = is_high && !string_end;

   assign enc_pair = utf8_encode(LIMIT_3BYTE + {1'b0, held_bits_ff, code_unit[9:0]});
   assign enc_held = utf8_encode({5'd0, HIGH_SURR_TAG, held_bits_ff});
   assign enc_cur  = utf8_encode({5'd0, code_unit});

   always_comb begin
      job           = '0;
      job.str_end   = string_end;
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      if (held_valid_ff && is_low) begin
         job.bytes[3:0] = enc_pair.b;
         job.count      = enc_pair.n;
      end else begin
         if (held_valid_ff) begin
            job.bytes[2:0] = enc_held.b[2:0];
            job.count      = 3'd3;
            if (!hold_now) begin
               job.bytes[5:3] = enc_cur.b[2:0];
               job.count      = 3'd3 + enc_cur.n;
            end
         end else if (!hold_now) begin
            job.bytes[3:0] = enc_cur.b;
            job.count      = enc_cur.n;
         end
      end
      if (accept) begin
         held_valid_in = hold_now && !(held_valid_ff && is_low);
         if (hold_now && !(held_valid_ff && is_low)) begin
            held_bits_in = code_unit[9:0];
         end
      end
   end

   // an item that only parks a high surrogate yields no job
   assign push = accept && (job.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

endmodule

/* hdl/u16u8_queue.sv */
`timescale 1ns / 1ps
// Short job queue between front and back end.
// Depends on u16u8_pkg.
module u16u8_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u16u8_pkg::job_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               nonempty,
   output u16u8_pkg::job_type head
);
   import u16u8_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   job_type           mem [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]     fill_ff, fill_in;

   assign full     = (fill_ff == (PtrW+1)'(QUEUE_DEPTH));
   assign nonempty = (fill_ff != '0);
   assign head     = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* hdl/u16u8_back.sv */
`timescale 1ns / 1ps
// Back end: walks the head job into the output register one byte per cycle while not stalled.
// Depends on u16u8_pkg.
module u16u8_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  u16u8_pkg::job_type job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last,
   output logic               rsp_string_last
);
   import u16u8_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       run_last_ff, run_last_in;
   logic       str_last_ff, str_last_in;
   logic       load, at_end;

   // output register free, or its byte leaves this cycle
   assign load   = !valid_ff || !rsp_stall;
   assign at_end = (idx_ff == job.count - 3'd1);
   assign pop    = load && job_valid && at_end;

   always_comb begin
      idx_in      = idx_ff;
      valid_in    = valid_ff;
      byte_in     = byte_ff;
      run_last_in = run_last_ff;
      str_last_in = str_last_ff;
      if (load) begin
         valid_in = job_valid;
         if (job_valid) begin
            byte_in     = job.bytes[idx_ff];
            run_last_in = at_end;
            str_last_in = at_end && job.str_end;
            idx_in      = at_end ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      run_last_ff <= run_last_in;
      str_last_ff <= str_last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_string_last = str_last_ff;

endmodule
